/* rtl/stok_pkg.sv */
package stok_pkg;

    localparam int SPAN_W = 16;

    // token kinds
    localparam logic [2:0] KIND_IDENT    = 3'd0;
    localparam logic [2:0] KIND_NUMBER   = 3'd1;
    localparam logic [2:0] KIND_STRING   = 3'd2;
    localparam logic [2:0] KIND_PUNCT    = 3'd3;
    localparam logic [2:0] KIND_SIMPLE   = 3'd4;
    localparam logic [2:0] KIND_COMPOUND = 3'd5;
    localparam logic [2:0] KIND_EOF      = 3'd6;
    localparam logic [2:0] KIND_ERROR    = 3'd7;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM     = 2'd2;

    // scan modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_INT    = 3'd2;
    localparam logic [2:0] MODE_DOT    = 3'd3;
    localparam logic [2:0] MODE_FRAC   = 3'd4;
    localparam logic [2:0] MODE_STRING = 3'd5;
    localparam logic [2:0] MODE_OP     = 3'd6;

    // character classes seen from the idle mode
    localparam logic [2:0] CLS_SPACE   = 3'd0;
    localparam logic [2:0] CLS_WORD    = 3'd1;
    localparam logic [2:0] CLS_DIGIT   = 3'd2;
    localparam logic [2:0] CLS_QUOTE   = 3'd3;
    localparam logic [2:0] CLS_PUNCT   = 3'd4;
    localparam logic [2:0] CLS_SIMPLE  = 3'd5;
    localparam logic [2:0] CLS_OPSTART = 3'd6;
    localparam logic [2:0] CLS_OTHER   = 3'd7;

    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic [7:0]        lead;
        logic [1:0]        err;
    } tok_rec_t;

    typedef struct packed {
        logic [1:0]           count;
        tok_rec_t [2:0]       recs;
    } tok_batch_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word_cont(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic [2:0] char_class(input logic [7:0] c);
        logic [2:0] cls;
        if ((c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13))) begin
            cls = CLS_SPACE;
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
            cls = CLS_WORD;
        end else if (is_digit(c)) begin
            cls = CLS_DIGIT;
        end else if (c == CH_QUOTE) begin
            cls = CLS_QUOTE;
        end else if ((c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
                     (c == CH_RBRACE) || (c == CH_SEMI) || (c == CH_COMMA)) begin
            cls = CLS_PUNCT;
        end else if ((c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
                     (c == CH_SLASH)) begin
            cls = CLS_SIMPLE;
        end else if ((c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT)) begin
            cls = CLS_OPSTART;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

/* rtl/stok_scan.sv */
module stok_scan
    import stok_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] item_byte,
    input  logic       item_end,
    input  logic       advance,
    output tok_batch_t batch
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [2:0]          mode_reg,  mode_next;
    logic [POS_BITS-1:0] begin_reg, begin_next;
    logic [POS_BITS-1:0] pos_reg,   pos_next;
    logic [7:0]          held_reg,  held_next;

    logic [POS_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] pos_before_dot;
    logic [1:0]          cnt;
    logic                do_start;

    function automatic tok_rec_t mk_rec(input logic [2:0] kind,
                                        input logic [POS_BITS-1:0] s,
                                        input logic [POS_BITS-1:0] e,
                                        input logic [7:0] lead,
                                        input logic [1:0] err);
        tok_rec_t r;
        r.kind       = kind;
        r.span_start = SPAN_W'(s);
        r.span_end   = SPAN_W'(e);
        r.lead       = lead;
        r.err        = err;
        return r;
    endfunction

    assign pos_inc        = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign pos_before_dot = (pos_reg > begin_reg) ? pos_reg - 1'b1 : begin_reg;

    always_comb begin
        batch.recs = '0;
        cnt        = 2'd0;
        do_start   = 1'b0;
        mode_next  = mode_reg;
        begin_next = begin_reg;
        held_next  = held_reg;
        pos_next   = pos_inc;

        if (item_end) begin
            // flush the pending token, then eof, then back to reset state
            case (mode_reg)
                MODE_IDENT: begin
                    batch.recs[cnt] = mk_rec(KIND_IDENT, begin_reg, pos_reg, held_reg, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
                MODE_INT, MODE_FRAC: begin
                    batch.recs[cnt] = mk_rec(KIND_NUMBER, begin_reg, pos_reg, held_reg, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
                MODE_DOT: begin
                    batch.recs[cnt] = mk_rec(KIND_NUMBER, begin_reg, pos_before_dot, held_reg,
                                             ERR_NONE);
                    cnt = cnt + 2'd1;
                    batch.recs[cnt] = mk_rec(KIND_ERROR, pos_before_dot, pos_reg, CH_DOT,
                                             ERR_UNEXPECTED);
                    cnt = cnt + 2'd1;
                end
                MODE_STRING: begin
                    batch.recs[cnt] = mk_rec(KIND_ERROR, begin_reg, pos_reg, CH_QUOTE, ERR_UNTERM);
                    cnt = cnt + 2'd1;
                end
                MODE_OP: begin
                    batch.recs[cnt] = mk_rec(KIND_SIMPLE, begin_reg, pos_reg, held_reg, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
            batch.recs[cnt] = mk_rec(KIND_EOF, pos_reg, pos_reg, CH_NUL, ERR_NONE);
            cnt = cnt + 2'd1;
            mode_next  = MODE_IDLE;
            begin_next = '0;
            held_next  = '0;
            pos_next   = '0;
        end else begin
            case (mode_reg)
                MODE_IDENT: begin
                    if (!is_word_cont(item_byte)) begin
                        batch.recs[cnt] = mk_rec(KIND_IDENT, begin_reg, pos_reg, held_reg,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (item_byte == CH_DOT) begin
                        mode_next = MODE_DOT;
                    end else if (!is_digit(item_byte)) begin
                        batch.recs[cnt] = mk_rec(KIND_NUMBER, begin_reg, pos_reg, held_reg,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (is_digit(item_byte)) begin
                        mode_next = MODE_FRAC;
                    end else begin
                        // number ends before the dot; the dot alone is an error
                        batch.recs[cnt] = mk_rec(KIND_NUMBER, begin_reg, pos_before_dot,
                                                 held_reg, ERR_NONE);
                        cnt = cnt + 2'd1;
                        batch.recs[cnt] = mk_rec(KIND_ERROR, pos_before_dot, pos_reg, CH_DOT,
                                                 ERR_UNEXPECTED);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (!is_digit(item_byte)) begin
                        batch.recs[cnt] = mk_rec(KIND_NUMBER, begin_reg, pos_reg, held_reg,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (item_byte == CH_QUOTE) begin
                        batch.recs[cnt] = mk_rec(KIND_STRING, begin_reg, pos_inc, CH_QUOTE,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_OP: begin
                    if (item_byte == CH_EQ) begin
                        batch.recs[cnt] = mk_rec(KIND_COMPOUND, begin_reg, pos_inc, held_reg,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_IDLE;
                    end else begin
                        batch.recs[cnt] = mk_rec(KIND_SIMPLE, begin_reg, pos_reg, held_reg,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start) begin
                mode_next = MODE_IDLE;
                case (char_class(item_byte))
                    CLS_SPACE: begin
                    end
                    CLS_WORD: begin
                        mode_next  = MODE_IDENT;
                        begin_next = pos_reg;
                        held_next  = item_byte;
                    end
                    CLS_DIGIT: begin
                        mode_next  = MODE_INT;
                        begin_next = pos_reg;
                        held_next  = item_byte;
                    end
                    CLS_QUOTE: begin
                        mode_next  = MODE_STRING;
                        begin_next = pos_reg;
                        held_next  = item_byte;
                    end
                    CLS_PUNCT: begin
                        batch.recs[cnt] = mk_rec(KIND_PUNCT, pos_reg, pos_inc, item_byte,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                    CLS_SIMPLE: begin
                        batch.recs[cnt] = mk_rec(KIND_SIMPLE, pos_reg, pos_inc, item_byte,
                                                 ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                    CLS_OPSTART: begin
                        mode_next  = MODE_OP;
                        begin_next = pos_reg;
                        held_next  = item_byte;
                    end
                    default: begin
                        batch.recs[cnt] = mk_rec(KIND_ERROR, pos_reg, pos_inc, item_byte,
                                                 ERR_UNEXPECTED);
                        cnt = cnt + 2'd1;
                    end
                endcase
            end
        end
        batch.count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            held_reg  <= '0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
        end
    end

endmodule

/* rtl/stok_outq.sv */
module stok_outq
    import stok_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  tok_batch_t batch,
    input  logic       m_ready,
    output logic       m_valid,
    output tok_rec_t   head,
    output logic       last,
    output logic       free
);

    tok_rec_t [2:0] rec_reg;
    logic [1:0]     cnt_reg;
    logic           pop;

    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign head    = rec_reg[0];
    // the queue only ever holds one item's records, so the last one left closes the run
    assign last    = (cnt_reg == 2'd1);
    assign free    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= batch.count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= batch.recs;
        end else if (pop) begin
            rec_reg <= {rec_reg[2], rec_reg[2], rec_reg[1]};
        end
    end

endmodule

/* rtl/source_tokenizer_top.sv */
// Streaming source scanner: one source byte per input transfer, token records out.
//
// Input channel (s_*): s_source_byte carries one character; s_end_of_source set
// marks end of source (the byte is then ignored). Result channel (m_*): one token
// record per transfer with kind, span, lead byte and error code; m_last_of_run
// flags the final record caused by one input transfer.
//
// An input transfer lands in the input register; its records are computed
// combinationally from it and loaded into the result queue, which drains one
// record per cycle while m_ready is high. Throughput: one input byte per cycle
// while each byte yields at most one record and m_ready is high; a byte whose
// records do not fit waits in the input register until the queue can take them.
//
// Reset (aresetn low, synchronous) empties the input register and result queue
// and puts the scanner idle at position zero. End of source does the same to the
// scanner state once it has flushed the pending token and sent eof.
// When m_ready is low, records hold in the result queue; the input register still
// absorbs bytes that produce no record, and s_ready drops once it is blocked.
module source_tokenizer_top
    import stok_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_source_byte,
    input  logic              s_end_of_source,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_token_kind,
    output logic [SPAN_W-1:0] m_span_start,
    output logic [SPAN_W-1:0] m_span_end,
    output logic [7:0]        m_lead_byte,
    output logic [1:0]        m_error_code,
    output logic              m_last_of_run
);

    logic       in_vld_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    tok_batch_t batch;
    tok_rec_t   head;
    logic       q_free;
    logic       proc;
    logic       load;

    // Advance the scanner when the held byte yields no record, or when the queue
    // is empty or emptying this cycle so the whole batch fits.
    assign proc    = in_vld_reg && ((batch.count == 2'd0) || q_free);
    assign load    = proc && (batch.count != 2'd0);
    assign s_ready = !in_vld_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (proc) begin
            in_vld_reg <= 1'b0;
        end
    end

    // Hold the payload until the scanner takes it.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_source_byte;
            end_reg  <= s_end_of_source;
        end
    end

    stok_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_byte (byte_reg),
        .item_end  (end_reg),
        .advance   (proc),
        .batch     (batch)
    );

    stok_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .batch   (batch),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .head    (head),
        .last    (m_last_of_run),
        .free    (q_free)
    );

    assign m_token_kind = head.kind;
    assign m_span_start = head.span_start;
    assign m_span_end   = head.span_end;
    assign m_lead_byte  = head.lead;
    assign m_error_code = head.err;

endmodule
